@@ src/mmt_pkg.sv @@
// Shared types, codes and character tables for the maximal munch tokenizer.
package mmt_pkg;

    // Position counter and field widths
    localparam int POSITION_BITS = 16;
    localparam int START_W       = 16;
    localparam int LEN_W         = 16;
    localparam int KIND_W        = 5;
    localparam int CLS_W         = 4;
    localparam int MODE_W        = 4;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Depth of the queue between front and back, and of the result queue
    localparam int MID_DEPTH = 4;
    localparam int MID_IDX_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_IDX_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Character classes
    localparam logic [CLS_W-1:0] CLS_SPACE  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_DIGIT  = 4'd1;
    localparam logic [CLS_W-1:0] CLS_LETTER = 4'd2;
    localparam logic [CLS_W-1:0] CLS_UNDER  = 4'd3;
    localparam logic [CLS_W-1:0] CLS_EQ     = 4'd4;
    localparam logic [CLS_W-1:0] CLS_MINUS  = 4'd5;
    localparam logic [CLS_W-1:0] CLS_SLASH  = 4'd6;
    localparam logic [CLS_W-1:0] CLS_GT     = 4'd7;
    localparam logic [CLS_W-1:0] CLS_SINGLE = 4'd8;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SPACE      = 5'd0;
    localparam logic [KIND_W-1:0] KIND_COMMENT    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_ASSIGN     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_EQUALITY   = 5'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS       = 5'd4;
    localparam logic [KIND_W-1:0] KIND_MINUS      = 5'd5;
    localparam logic [KIND_W-1:0] KIND_MOVE       = 5'd6;
    localparam logic [KIND_W-1:0] KIND_MOVE_UNDER = 5'd7;
    localparam logic [KIND_W-1:0] KIND_TIMES      = 5'd8;
    localparam logic [KIND_W-1:0] KIND_DIVIDE     = 5'd9;
    localparam logic [KIND_W-1:0] KIND_CUT        = 5'd10;
    localparam logic [KIND_W-1:0] KIND_CUT_UNDER  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_LT         = 5'd12;
    localparam logic [KIND_W-1:0] KIND_GT         = 5'd13;
    localparam logic [KIND_W-1:0] KIND_OPEN       = 5'd14;
    localparam logic [KIND_W-1:0] KIND_CLOSE      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_DQUOTE     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_COMMA      = 5'd17;
    localparam logic [KIND_W-1:0] KIND_DOT        = 5'd18;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd20;
    localparam logic [KIND_W-1:0] KIND_NAME       = 5'd21;

    // Lexer modes
    localparam logic [MODE_W-1:0] M_IDLE   = 4'd0;
    localparam logic [MODE_W-1:0] M_SPACE  = 4'd1;
    localparam logic [MODE_W-1:0] M_NUMBER = 4'd2;
    localparam logic [MODE_W-1:0] M_NAME   = 4'd3;
    localparam logic [MODE_W-1:0] M_EQ     = 4'd4;
    localparam logic [MODE_W-1:0] M_MINUS  = 4'd5;
    localparam logic [MODE_W-1:0] M_MOVE   = 4'd6;
    localparam logic [MODE_W-1:0] M_SLASH  = 4'd7;
    localparam logic [MODE_W-1:0] M_CUT    = 4'd8;

    // Input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } mmt_in_t;

    // Result beat
    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [START_W-1:0] token_start;
        logic [LEN_W-1:0]   token_length;
        logic               is_operator;
        logic [7:0]         unknown_byte;
        logic               last_of_run;
    } mmt_token_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [CLS_W-1:0]         cls;
        logic [KIND_W-1:0]        kind;
        logic [7:0]               text_byte;
        logic                     end_of_text;
        logic [POSITION_BITS-1:0] at;
    } mmt_item_t;

    // Result write group from lexer to result queue
    typedef struct packed {
        logic [1:0] count;
        mmt_token_t first;
        mmt_token_t second;
    } mmt_wr_t;

    function automatic logic [CLS_W-1:0] classify(input logic [7:0] c);
        logic [CLS_W-1:0] cls;
        cls = CLS_SINGLE;
        if (c == 8'h20)                                   cls = CLS_SPACE;
        else if (c >= 8'h30 && c <= 8'h39)                cls = CLS_DIGIT;
        else if ((c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h41 && c <= 8'h5A))              cls = CLS_LETTER;
        else if (c == 8'h5F)                              cls = CLS_UNDER;
        else if (c == 8'h3D)                              cls = CLS_EQ;
        else if (c == 8'h2D)                              cls = CLS_MINUS;
        else if (c == 8'h2F)                              cls = CLS_SLASH;
        else if (c == 8'h3E)                              cls = CLS_GT;
        return cls;
    endfunction

    // Kind of a byte that stands alone as a one-byte token
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h23:   k = KIND_COMMENT;
            8'h2B:   k = KIND_PLUS;
            8'h2A:   k = KIND_TIMES;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h28:   k = KIND_OPEN;
            8'h29:   k = KIND_CLOSE;
            8'h22:   k = KIND_DQUOTE;
            8'h2C:   k = KIND_COMMA;
            8'h2E:   k = KIND_DOT;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pending_kind(input logic [MODE_W-1:0] m);
        logic [KIND_W-1:0] k;
        case (m)
            M_SPACE:  k = KIND_SPACE;
            M_NUMBER: k = KIND_NUMBER;
            M_NAME:   k = KIND_NAME;
            M_EQ:     k = KIND_ASSIGN;
            M_MINUS:  k = KIND_MINUS;
            M_MOVE:   k = KIND_MOVE;
            M_SLASH:  k = KIND_DIVIDE;
            M_CUT:    k = KIND_CUT;
            default:  k = KIND_SPACE;
        endcase
        return k;
    endfunction

    function automatic mmt_token_t make_token(
        input logic [KIND_W-1:0]        kind,
        input logic [POSITION_BITS-1:0] start,
        input logic [LEN_W-1:0]         len,
        input logic [7:0]               unk
    );
        mmt_token_t t;
        t.token_kind   = kind;
        t.token_start  = START_W'(start);
        t.token_length = len;
        t.is_operator  = (kind == KIND_DIVIDE) || (kind == KIND_PLUS) ||
                         (kind == KIND_MINUS) || (kind == KIND_TIMES) ||
                         (kind == KIND_EQUALITY);
        t.unknown_byte = unk;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

@@ src/mmt_front.sv @@
// Front stage: takes input beats, classifies the byte and tags its position.
module mmt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mmt_pkg::mmt_in_t  item,
    output logic              full,
    output logic              st_valid,
    output mmt_pkg::mmt_item_t st_item,
    input  logic              mid_full
);

    logic                              valid_reg;
    logic                              valid_next;
    mmt_pkg::mmt_item_t                item_reg;
    logic [mmt_pkg::POSITION_BITS-1:0] pos_reg;
    logic [mmt_pkg::POSITION_BITS-1:0] pos_next;
    logic                              accept;
    logic                              drain;

    // Stage drains into the queue whenever the queue has room
    assign drain  = valid_reg && !mid_full;
    assign full   = valid_reg && mid_full;
    assign accept = push && !full;

    assign st_valid = valid_reg;
    assign st_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (drain)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    // Restart position on end of text, otherwise advance with wrap
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (item.end_of_text)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + mmt_pkg::POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    // Capture classified beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cls         <= mmt_pkg::classify(item.text_byte);
            item_reg.kind        <= mmt_pkg::single_kind(item.text_byte);
            item_reg.text_byte   <= item.text_byte;
            item_reg.end_of_text <= item.end_of_text;
            item_reg.at          <= pos_reg;
        end
    end

endmodule

@@ src/mmt_fifo.sv @@
// Short queue of classified bytes between the front and the lexer.
module mmt_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  mmt_pkg::mmt_item_t wr_item,
    output logic               is_full,
    input  logic               rd_en,
    output logic               rd_valid,
    output mmt_pkg::mmt_item_t rd_item
);

    mmt_pkg::mmt_item_t                  entry_reg [mmt_pkg::MID_DEPTH];
    logic [mmt_pkg::MID_IDX_W-1:0]       wp_reg;
    logic [mmt_pkg::MID_IDX_W-1:0]       wp_next;
    logic [mmt_pkg::MID_IDX_W-1:0]       rp_reg;
    logic [mmt_pkg::MID_IDX_W-1:0]       rp_next;
    logic [mmt_pkg::MID_CNT_W-1:0]       count_reg;
    logic [mmt_pkg::MID_CNT_W-1:0]       count_next;
    logic                                do_wr;
    logic                                do_rd;

    assign is_full  = (count_reg == mmt_pkg::MID_CNT_W'(mmt_pkg::MID_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rp_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wp_next    = do_wr ? wp_reg + mmt_pkg::MID_IDX_W'(1) : wp_reg;
        rp_next    = do_rd ? rp_reg + mmt_pkg::MID_IDX_W'(1) : rp_reg;
        count_next = count_reg + mmt_pkg::MID_CNT_W'(do_wr) - mmt_pkg::MID_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wp_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mmt_pkg::MID_CNT_W'(mmt_pkg::MID_DEPTH))
        else $error("mid queue overfilled");

    a_no_wr_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        is_full && !do_rd |=> is_full)
        else $error("mid queue lost an entry while full");

endmodule

@@ src/mmt_back.sv @@
// Lexer: runs the longest-match mode machine and forms up to two tokens per byte.
module mmt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mmt_pkg::mmt_item_t in_item,
    output logic               take,
    input  logic               room,
    output mmt_pkg::mmt_wr_t   wr
);

    logic [mmt_pkg::MODE_W-1:0]        mode_reg;
    logic [mmt_pkg::MODE_W-1:0]        mode_next;
    logic [mmt_pkg::POSITION_BITS-1:0] start_reg;
    logic [mmt_pkg::POSITION_BITS-1:0] start_next;
    logic [mmt_pkg::LEN_W-1:0]         len_reg;
    logic [mmt_pkg::LEN_W-1:0]         len_next;

    logic               taken;
    logic               grow;
    logic               e1_valid;
    logic               e2_valid;
    logic               e3_valid;
    mmt_pkg::mmt_token_t e1;
    mmt_pkg::mmt_token_t e2;
    mmt_pkg::mmt_token_t e3;
    logic [1:0]          n;

    assign take = in_valid && room;

    // Step the mode machine for the byte at the head of the queue
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        taken      = 1'b0;
        grow       = 1'b0;
        e1_valid   = 1'b0;
        e2_valid   = 1'b0;
        e3_valid   = 1'b0;
        e1 = mmt_pkg::make_token(mmt_pkg::KIND_SPACE, start_reg, len_reg, 8'd0);
        e2 = e1;
        e3 = e1;

        case (mode_reg)
            mmt_pkg::M_IDLE:
            begin
                mode_next = mmt_pkg::M_IDLE;
            end
            mmt_pkg::M_SPACE:
            begin
                grow = (in_item.cls == mmt_pkg::CLS_SPACE);
            end
            mmt_pkg::M_NUMBER:
            begin
                grow = (in_item.cls == mmt_pkg::CLS_DIGIT);
            end
            mmt_pkg::M_NAME:
            begin
                grow = (in_item.cls == mmt_pkg::CLS_LETTER) ||
                       (in_item.cls == mmt_pkg::CLS_DIGIT) ||
                       (in_item.cls == mmt_pkg::CLS_UNDER);
            end
            mmt_pkg::M_EQ:
            begin
                if (in_item.cls == mmt_pkg::CLS_EQ)
                begin
                    taken     = 1'b1;
                    e1_valid  = 1'b1;
                    e1 = mmt_pkg::make_token(mmt_pkg::KIND_EQUALITY, start_reg,
                                             mmt_pkg::LEN_W'(2), 8'd0);
                    mode_next = mmt_pkg::M_IDLE;
                end
            end
            mmt_pkg::M_MINUS:
            begin
                if (in_item.cls == mmt_pkg::CLS_GT)
                begin
                    taken     = 1'b1;
                    mode_next = mmt_pkg::M_MOVE;
                    len_next  = mmt_pkg::LEN_W'(2);
                end
            end
            mmt_pkg::M_SLASH:
            begin
                if (in_item.cls == mmt_pkg::CLS_GT)
                begin
                    taken     = 1'b1;
                    mode_next = mmt_pkg::M_CUT;
                    len_next  = mmt_pkg::LEN_W'(2);
                end
            end
            mmt_pkg::M_MOVE, mmt_pkg::M_CUT:
            begin
                if (in_item.cls == mmt_pkg::CLS_UNDER)
                begin
                    taken    = 1'b1;
                    e1_valid = 1'b1;
                    e1 = mmt_pkg::make_token(
                        (mode_reg == mmt_pkg::M_MOVE) ? mmt_pkg::KIND_MOVE_UNDER
                                                      : mmt_pkg::KIND_CUT_UNDER,
                        start_reg, mmt_pkg::LEN_W'(3), 8'd0);
                    mode_next = mmt_pkg::M_IDLE;
                end
            end
            default:
            begin
                mode_next = mmt_pkg::M_IDLE;
            end
        endcase

        // Extend the pending run, holding at the saturation limit
        if (grow)
        begin
            taken = 1'b1;
            if (len_reg != mmt_pkg::LEN_MAX)
            begin
                len_next = len_reg + mmt_pkg::LEN_W'(1);
            end
        end

        // Close the pending token, then start a new one or emit a single
        if (!taken)
        begin
            if (mode_next != mmt_pkg::M_IDLE)
            begin
                e1_valid = 1'b1;
                e1 = mmt_pkg::make_token(mmt_pkg::pending_kind(mode_next),
                                         start_next, len_next, 8'd0);
            end
            start_next = in_item.at;
            len_next   = mmt_pkg::LEN_W'(1);
            case (in_item.cls)
                mmt_pkg::CLS_SPACE:  mode_next = mmt_pkg::M_SPACE;
                mmt_pkg::CLS_DIGIT:  mode_next = mmt_pkg::M_NUMBER;
                mmt_pkg::CLS_LETTER: mode_next = mmt_pkg::M_NAME;
                mmt_pkg::CLS_EQ:     mode_next = mmt_pkg::M_EQ;
                mmt_pkg::CLS_MINUS:  mode_next = mmt_pkg::M_MINUS;
                mmt_pkg::CLS_SLASH:  mode_next = mmt_pkg::M_SLASH;
                default:
                begin
                    mode_next  = mmt_pkg::M_IDLE;
                    start_next = start_reg;
                    len_next   = len_reg;
                    e2_valid   = 1'b1;
                    e2 = mmt_pkg::make_token(
                        in_item.kind, in_item.at, mmt_pkg::LEN_W'(1),
                        (in_item.kind == mmt_pkg::KIND_UNKNOWN) ? in_item.text_byte : 8'd0);
                end
            endcase
        end

        // Flush on the last byte of a text
        if (in_item.end_of_text)
        begin
            if (mode_next != mmt_pkg::M_IDLE)
            begin
                e3_valid = 1'b1;
                e3 = mmt_pkg::make_token(mmt_pkg::pending_kind(mode_next),
                                         start_next, len_next, 8'd0);
            end
            mode_next  = mmt_pkg::M_IDLE;
            start_next = '0;
            len_next   = '0;
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb
    begin
        n = 2'(e1_valid) + 2'(e2_valid) + 2'(e3_valid);
        wr.first  = e1_valid ? e1 : (e2_valid ? e2 : e3);
        wr.second = (e1_valid && e2_valid) ? e2 : e3;
        wr.first.last_of_run  = (n == 2'd1);
        wr.second.last_of_run = 1'b1;
        wr.count = take ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mmt_pkg::M_IDLE;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_item.end_of_text |=> mode_reg == mmt_pkg::M_IDLE)
        else $error("lexer not idle after end of text");

    a_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        !(e1_valid && e2_valid && e3_valid))
        else $error("lexer formed three tokens for one byte");

endmodule

@@ src/mmt_outq.sv @@
// Result queue: takes up to two tokens per cycle, releases one per pop.
module mmt_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  mmt_pkg::mmt_wr_t    wr,
    output logic                room,
    input  logic                pop,
    output logic                empty,
    output mmt_pkg::mmt_token_t token
);

    mmt_pkg::mmt_token_t           entry_reg [mmt_pkg::OUT_DEPTH];
    logic [mmt_pkg::OUT_IDX_W-1:0] wp_reg;
    logic [mmt_pkg::OUT_IDX_W-1:0] wp_next;
    logic [mmt_pkg::OUT_IDX_W-1:0] wp_plus1;
    logic [mmt_pkg::OUT_IDX_W-1:0] rp_reg;
    logic [mmt_pkg::OUT_IDX_W-1:0] rp_next;
    logic [mmt_pkg::OUT_CNT_W-1:0] count_reg;
    logic [mmt_pkg::OUT_CNT_W-1:0] count_next;
    logic                          do_rd;

    // Room for a full two-token write
    assign room     = (count_reg <= mmt_pkg::OUT_CNT_W'(mmt_pkg::OUT_DEPTH - 2));
    assign empty    = (count_reg == '0);
    assign token    = entry_reg[rp_reg];
    assign do_rd    = pop && !empty;
    assign wp_plus1 = wp_reg + mmt_pkg::OUT_IDX_W'(1);

    always_comb
    begin
        wp_next    = wp_reg + mmt_pkg::OUT_IDX_W'(wr.count);
        rp_next    = do_rd ? rp_reg + mmt_pkg::OUT_IDX_W'(1) : rp_reg;
        count_next = count_reg + mmt_pkg::OUT_CNT_W'(wr.count)
                     - mmt_pkg::OUT_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Write one or two tokens at consecutive slots
    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            entry_reg[wp_reg] <= wr.first;
        end
        if (wr.count == 2'd2)
        begin
            entry_reg[wp_plus1] <= wr.second;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mmt_pkg::OUT_CNT_W'(mmt_pkg::OUT_DEPTH))
        else $error("result queue overfilled");

    a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
        wr.count != 2'd0 |-> room)
        else $error("result write without room");

endmodule

@@ src/maximal_munch_tokenizer_top.sv @@
// Path: an accepted byte is registered in the front stage, written to the mid queue, then lexed into the result queue.
// Throughput: one byte per cycle while the mid queue and the result queue have room; tokens leave one
// per pop, so a byte that closes a pending token and emits another leaves two tokens to pop.
// Reset (rst_n low, asynchronous) empties both queues, idles the lexer and zeroes the
// byte position.
// Top level of the maximal munch tokenizer.
module maximal_munch_tokenizer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmt_pkg::mmt_in_t    item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mmt_pkg::mmt_token_t token
);

    logic               st_valid;
    mmt_pkg::mmt_item_t st_item;
    logic               mid_full;
    logic               mid_valid;
    mmt_pkg::mmt_item_t mid_item;
    logic               take;
    logic               room;
    mmt_pkg::mmt_wr_t   wr;

    mmt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .st_valid (st_valid),
        .st_item  (st_item),
        .mid_full (mid_full)
    );

    mmt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (st_valid),
        .wr_item  (st_item),
        .is_full  (mid_full),
        .rd_en    (take),
        .rd_valid (mid_valid),
        .rd_item  (mid_item)
    );

    mmt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_valid),
        .in_item  (mid_item),
        .take     (take),
        .room     (room),
        .wr       (wr)
    );

    mmt_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .room  (room),
        .pop   (pop),
        .empty (empty),
        .token (token)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the maximal munch tokenizer top level.
module tb;
    import mmt_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 3;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 340;
    localparam int LONG_RUN     = 300;
    localparam int MAX_REPORTS  = 10;

    // Characters the lexer treats specially
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_OPEN   = "(";
    localparam logic [7:0] CH_CLOSE  = ")";
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_LOW_A  = "a";
    localparam logic [7:0] CH_LOW_Z  = "z";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_Z   = "Z";

    typedef enum int {PH_DIRECTED, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       pop   = 1'b0;
    mmt_in_t    item  = '0;
    logic       full;
    logic       empty;
    mmt_token_t token;

    phase_t phase          = PH_DIRECTED;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_count     = 0;
    int     idle_cycles    = 0;
    int     errors         = 0;
    int     bytes_in       = 0;
    int     tokens_out     = 0;
    int     beats_queued   = 0;
    int     texts          = 0;

    mmt_in_t    beat_q[$];
    mmt_token_t want_q[$];
    mmt_token_t step_toks[$];

    // Lexer state mirrored by the predictor
    logic [MODE_W-1:0] lx_mode  = M_IDLE;
    logic [15:0]       lx_start = '0;
    logic [15:0]       lx_len   = '0;
    logic [15:0]       lx_pos   = '0;

    maximal_munch_tokenizer_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .token (token)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic is_digit_c(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_letter_c(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic mmt_token_t form_token(input logic [KIND_W-1:0] kind,
                                              input logic [15:0] start,
                                              input logic [15:0] len,
                                              input logic [7:0] unk);
        mmt_token_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.is_operator  = kind == KIND_DIVIDE || kind == KIND_PLUS || kind == KIND_MINUS ||
                         kind == KIND_TIMES || kind == KIND_EQUALITY;
        t.unknown_byte = unk;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Kind of the token held open in a given mode
    function automatic logic [KIND_W-1:0] held_kind(input logic [MODE_W-1:0] mode);
        case (mode)
            M_NUMBER: return KIND_NUMBER;
            M_NAME:   return KIND_NAME;
            M_EQ:     return KIND_ASSIGN;
            M_MINUS:  return KIND_MINUS;
            M_MOVE:   return KIND_MOVE;
            M_SLASH:  return KIND_DIVIDE;
            M_CUT:    return KIND_CUT;
            default:  return KIND_SPACE;
        endcase
    endfunction

    // Kind of a byte that forms a token on its own
    function automatic logic [KIND_W-1:0] lone_kind(input logic [7:0] c);
        case (c)
            CH_HASH:   return KIND_COMMENT;
            CH_PLUS:   return KIND_PLUS;
            CH_STAR:   return KIND_TIMES;
            CH_LT:     return KIND_LT;
            CH_GT:     return KIND_GT;
            CH_OPEN:   return KIND_OPEN;
            CH_CLOSE:  return KIND_CLOSE;
            CH_DQUOTE: return KIND_DQUOTE;
            CH_COMMA:  return KIND_COMMA;
            CH_DOT:    return KIND_DOT;
            default:   return KIND_UNKNOWN;
        endcase
    endfunction

    task automatic close_pending();
        if (lx_mode != M_IDLE)
            step_toks.insert(step_toks.size(),
                             form_token(held_kind(lx_mode), lx_start, lx_len, 8'h00));
        lx_mode = M_IDLE;
    endtask

    task automatic open_pending(input logic [MODE_W-1:0] mode, input logic [15:0] at);
        lx_mode  = mode;
        lx_start = at;
        lx_len   = 16'd1;
    endtask

    task automatic grow_pending();
        if (lx_len != LEN_MAX)
            lx_len = lx_len + 16'd1;
    endtask

    // Advance the lexer by one byte and queue the tokens it closes
    task automatic lex_byte(input mmt_in_t beat);
        logic [7:0]        c;
        logic [15:0]       at;
        logic              taken;
        logic [KIND_W-1:0] k;
        c     = beat.text_byte;
        at    = lx_pos;
        taken = 1'b0;
        step_toks.delete();
        case (lx_mode)
            M_SPACE:
                if (c == CH_SPACE)
                begin
                    grow_pending();
                    taken = 1'b1;
                end
            M_NUMBER:
                if (is_digit_c(c))
                begin
                    grow_pending();
                    taken = 1'b1;
                end
            M_NAME:
                if (is_letter_c(c) || is_digit_c(c) || c == CH_UNDER)
                begin
                    grow_pending();
                    taken = 1'b1;
                end
            M_EQ:
                if (c == CH_EQ)
                begin
                    step_toks.insert(step_toks.size(),
                                     form_token(KIND_EQUALITY, lx_start, 16'd2, 8'h00));
                    lx_mode = M_IDLE;
                    taken   = 1'b1;
                end
            M_MINUS, M_SLASH:
                if (c == CH_GT)
                begin
                    lx_mode = (lx_mode == M_MINUS) ? M_MOVE : M_CUT;
                    lx_len  = 16'd2;
                    taken   = 1'b1;
                end
            M_MOVE, M_CUT:
                if (c == CH_UNDER)
                begin
                    k = (lx_mode == M_MOVE) ? KIND_MOVE_UNDER : KIND_CUT_UNDER;
                    step_toks.insert(step_toks.size(), form_token(k, lx_start, 16'd3, 8'h00));
                    lx_mode = M_IDLE;
                    taken   = 1'b1;
                end
            default:
                lx_mode = M_IDLE;
        endcase

        // Close what is pending and start from the new byte
        if (!taken)
        begin
            close_pending();
            if (c == CH_SPACE)
                open_pending(M_SPACE, at);
            else if (is_digit_c(c))
                open_pending(M_NUMBER, at);
            else if (is_letter_c(c))
                open_pending(M_NAME, at);
            else if (c == CH_EQ)
                open_pending(M_EQ, at);
            else if (c == CH_MINUS)
                open_pending(M_MINUS, at);
            else if (c == CH_SLASH)
                open_pending(M_SLASH, at);
            else
            begin
                k = lone_kind(c);
                step_toks.insert(step_toks.size(),
                                 form_token(k, at, 16'd1, (k == KIND_UNKNOWN) ? c : 8'h00));
            end
        end

        // Flush at the end of a text and restart the position
        if (beat.end_of_text)
        begin
            close_pending();
            lx_start = '0;
            lx_len   = '0;
            lx_pos   = '0;
        end
        else
            lx_pos = lx_pos + 16'd1;

        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last_of_run = 1'b1;
        foreach (step_toks[i])
            want_q.insert(want_q.size(), step_toks[i]);
    endtask

    // Accept beats on both sides and check tokens at the rising edge
    always @(posedge clk)
    begin : monitor
        logic       moved;
        mmt_token_t want;
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                lex_byte(item);
                beat_q.delete(0);
                bytes_in++;
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (want_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("tb: unexpected token kind %0d start %0d len %0d",
                                 token.token_kind, token.token_start, token.token_length);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (token.token_kind !== want.token_kind ||
                        token.token_start !== want.token_start ||
                        token.token_length !== want.token_length ||
                        token.is_operator !== want.is_operator ||
                        token.unknown_byte !== want.unknown_byte ||
                        token.last_of_run !== want.last_of_run)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("tb: token %0d want kind %0d start %0d len %0d op %0b %s",
                                     tokens_out, want.token_kind, want.token_start,
                                     want.token_length, want.is_operator,
                                     $sformatf("unk %02h last %0b",
                                               want.unknown_byte, want.last_of_run));
                            $display("tb: token %0d got  kind %0d start %0d len %0d op %0b %s",
                                     tokens_out, token.token_kind, token.token_start,
                                     token.token_length, token.is_operator,
                                     $sformatf("unk %02h last %0b",
                                               token.unknown_byte, token.last_of_run));
                        end
                    end
                    tokens_out++;
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Offer the oldest pending byte, idling at random
    always @(negedge clk)
    begin
        if (rst_n && beat_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push <= 1'b1;
            item <= beat_q[0];
        end
        else
            push <= 1'b0;
    end

    // Pop tokens, holding off for a long stretch at the start of the free phase
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (phase == PH_FREE && hold_count < HOLD_CYCLES)
        begin
            pop        <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run when nothing moves for too long
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("maximal_munch_tokenizer_top: mismatch");
        $finish;
    end

    task automatic add_beat(input logic [7:0] c, input logic eot);
        mmt_in_t b;
        b.text_byte   = c;
        b.end_of_text = eot;
        beat_q.insert(beat_q.size(), b);
        beats_queued++;
    endtask

    task automatic add_string(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++)
            add_beat(s[i], eot_last && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0)
            return CH_LOW_A + 8'($urandom_range(0, 25));
        return CH_UP_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(0, 2))
            0:       return rand_letter();
            1:       return rand_digit();
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 9))
            0:       return CH_HASH;
            1:       return CH_PLUS;
            2:       return CH_STAR;
            3:       return CH_LT;
            4:       return CH_GT;
            5:       return CH_OPEN;
            6:       return CH_CLOSE;
            7:       return CH_DQUOTE;
            8:       return CH_COMMA;
            default: return CH_DOT;
        endcase
    endfunction

    // Bytes the lexer never accepts at the start of a token
    function automatic logic [7:0] rand_odd_byte();
        case ($urandom_range(0, 2))
            0:       return CH_TAB;
            1:       return CH_UNDER;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // Queue one text built from token fragments, with a little noise
    task automatic add_text();
        mmt_in_t tail;
        int      frags;
        frags = $urandom_range(1, 10);
        repeat (frags)
        begin
            case ($urandom_range(0, 19))
                0, 14:
                    repeat ($urandom_range(1, 3)) add_beat(CH_SPACE, 1'b0);
                1, 15:
                    repeat ($urandom_range(1, 4)) add_beat(rand_digit(), 1'b0);
                2, 16, 17:
                begin
                    add_beat(rand_letter(), 1'b0);
                    repeat ($urandom_range(0, 4)) add_beat(rand_name_char(), 1'b0);
                end
                3:       add_string("=", 1'b0);
                4:       add_string("==", 1'b0);
                5:       add_string("-", 1'b0);
                6:       add_string("->", 1'b0);
                7:       add_string("->_", 1'b0);
                8:       add_string("/", 1'b0);
                9:       add_string("/>", 1'b0);
                10:      add_string("/>_", 1'b0);
                11, 18:  add_beat(rand_punct(), 1'b0);
                12:      add_beat(8'($urandom_range(0, 255)), 1'b0);
                default: add_beat(rand_odd_byte(), 1'b0);
            endcase
        end
        // Mark the last byte as the end of the text
        tail = beat_q.pop_back();
        tail.end_of_text = 1'b1;
        beat_q.insert(beat_q.size(), tail);
        texts++;
    endtask

    task automatic add_random(input int n_items);
        int first;
        first = beats_queued;
        while (beats_queued - first < n_items)
            add_text();
    endtask

    task automatic enter_phase(input phase_t p, input int send_pct, input int recv_pct);
        phase          = p;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Hold the sender until every queued byte is in and every token is out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beat_q.size() != 0 || want_q.size() != 0);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte extremes, unknowns, every compound operator and each prefix but a lone slash
        enter_phase(PH_DIRECTED, 0, 0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(CH_TAB, 1'b0);
        add_string("_x_9 ===->_->/>_/>", 1'b1);
        add_string("42", 1'b1);
        add_string("-", 1'b1);
        add_string("#", 1'b1);
        // Long space run held pending across many beats
        for (int i = 0; i < LONG_RUN; i++)
            add_beat(CH_SPACE, 1'b0);
        add_string("ab", 1'b1);
        wait_drained();

        enter_phase(PH_FREE, 0, 0);
        add_random(PHASE_ITEMS);
        wait_drained();

        enter_phase(PH_SEND_IDLE, 74, 0);
        add_random(PHASE_ITEMS);
        wait_drained();

        enter_phase(PH_RECV_STALL, 0, 74);
        add_random(PHASE_ITEMS);
        wait_drained();

        enter_phase(PH_BOTH, 28, 28);
        add_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d bytes in %0d texts lexed, %0d tokens checked, %0d mismatches",
                 bytes_in, texts, tokens_out, errors);
        $display("tb: free, sender-idle, receiver-stall and mixed phases plus a %0d byte run",
                 LONG_RUN);
        if (errors == 0 && want_q.size() == 0)
            $display("maximal_munch_tokenizer_top: match");
        else
            $display("maximal_munch_tokenizer_top: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
src/mmt_pkg.sv
src/mmt_front.sv
src/mmt_fifo.sv
src/mmt_back.sv
src/mmt_outq.sv
src/maximal_munch_tokenizer_top.sv
tb/tb.sv
